// ===== hw/rtl/bspe_pkg.sv =====
// bspe_pkg: shared sizes, command and status codes and control structs
// for the byte stack program evaluator; no dependencies
package bspe_pkg;

   localparam int STACK_DEPTH    = 64;
   localparam int POSITION_LIMIT = 1024;

   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam int POS_W   = $clog2(POSITION_LIMIT);

   localparam int CMD_W    = 4;
   localparam int DATA_W   = 8;
   localparam int STATUS_W = 2;
   localparam int DETAIL_W = 10;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH0  = 4'd0,
      CMD_PUSH1  = 4'd1,
      CMD_PUSHA  = 4'd2,
      CMD_NOT    = 4'd3,
      CMD_SHL1   = 4'd4,
      CMD_SHR1   = 4'd5,
      CMD_SHR2   = 4'd6,
      CMD_SHR4   = 4'd7,
      CMD_AND    = 4'd8,
      CMD_OR     = 4'd9,
      CMD_XOR    = 4'd10,
      CMD_ADD    = 4'd11,
      CMD_IFZERO = 4'd12
   } cmd_type;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DEPTH = 2'd2;

   // how the stack shifts for one instruction
   typedef enum logic [2:0] {
      SOP_HOLD    = 3'd0,
      SOP_PUSH    = 3'd1,
      SOP_REPLACE = 3'd2,
      SOP_POP1    = 3'd3,
      SOP_POP2    = 3'd4
   } stack_op_type;

   typedef struct packed {
      logic                bad;
      stack_op_type        op;
      logic [DATA_W-1:0]   top;
      logic [DEPTH_W-1:0]  depth_next;
   } exec_type;

   // low detail bits of a count of any width up to 32
   function automatic logic [DETAIL_W-1:0] to_detail(input logic [31:0] v);
      return v[DETAIL_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/byte_stack_program_evaluator_top.sv =====
// byte_stack_program_evaluator_top: postfix byte stack program evaluator
// depends on bspe_pkg, bspe_exec and bspe_stack
//
//  channel | dir | handshake            | word
//  req     | in  | req_tvalid/req_tready | tdata: command, argument; tlast: last
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: status, value, detail
//
// one instruction word per cycle, except while a last word waits for the result register;
// a word in the input register is decoded and drives the top-three-entry stack update
// on the last word, rsp_tvalid comes from the result register, loaded from the input register
// a last word waits in the input register only while the result register is
// full and rsp_tready is low; other words never wait on the result side
// synchronous reset clears the control state; the stack itself is not reset
module byte_stack_program_evaluator_top
   import bspe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [3:0] command, [11:4] argument, [15:12] zero
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [1:0] status, [9:2] value, [19:10] detail, zero above
);

   localparam logic [POS_W-1:0] POS_MAX = POS_W'(POSITION_LIMIT - 1);

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [CMD_W-1:0]   in_cmd_ff;
   logic [DATA_W-1:0]  in_arg_ff;
   logic               in_last_ff;

   // program state
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [POS_W-1:0]   index_ff, index_in;
   logic               err_ff, err_in;
   logic [POS_W-1:0]   err_idx_ff, err_idx_in;

   // result register
   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [DATA_W-1:0]   out_value_ff, out_value_in;
   logic [DETAIL_W-1:0] out_detail_ff, out_detail_in;

   logic               out_free;
   logic               exe_fire;
   logic               stk_enable;
   logic [DATA_W-1:0]  s0, s1, s2;
   exec_type           ex;

   // a last word needs a free result slot, others always proceed
   assign out_free   = !out_valid_ff || rsp_tready;
   assign exe_fire   = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || exe_fire;
   assign stk_enable = exe_fire && !err_ff;

   bspe_exec u_exec (
      .cmd   (in_cmd_ff),
      .arg   (in_arg_ff),
      .s0    (s0),
      .s1    (s1),
      .s2    (s2),
      .depth (depth_ff),
      .ex    (ex)
   );

   bspe_stack u_stack (
      .clock  (clock),
      .enable (stk_enable),
      .ex     (ex),
      .s0     (s0),
      .s1     (s1),
      .s2     (s2)
   );

   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_comb begin
      logic               err_n;
      logic [POS_W-1:0]   err_idx_n;
      logic [DEPTH_W-1:0] depth_n;

      err_n     = err_ff;
      err_idx_n = err_idx_ff;
      depth_n   = depth_ff;
      // once an error is latched the stack and depth freeze
      if (!err_ff) begin
         if (ex.bad) begin
            err_n     = 1'b1;
            err_idx_n = index_ff;
         end else begin
            depth_n = ex.depth_next;
         end
      end

      depth_in      = depth_ff;
      index_in      = index_ff;
      err_in        = err_ff;
      err_idx_in    = err_idx_ff;
      out_status_in = out_status_ff;
      out_value_in  = out_value_ff;
      out_detail_in = out_detail_ff;

      if (exe_fire) begin
         if (in_last_ff) begin
            // report and clear for the next program
            depth_in   = '0;
            index_in   = '0;
            err_in     = 1'b0;
            err_idx_in = '0;
            if (err_n) begin
               out_status_in = STATUS_RANGE;
               out_value_in  = '0;
               out_detail_in = to_detail(32'(err_idx_n));
            end else if (depth_n != DEPTH_W'(1)) begin
               out_status_in = STATUS_DEPTH;
               out_value_in  = '0;
               out_detail_in = to_detail(32'(depth_n));
            end else begin
               out_status_in = STATUS_OK;
               out_value_in  = ex.top;
               out_detail_in = '0;
            end
         end else begin
            depth_in   = depth_n;
            err_in     = err_n;
            err_idx_in = err_idx_n;
            // position saturates at POSITION_LIMIT - 1
            if (index_ff != POS_MAX) begin
               index_in = index_ff + POS_W'(1);
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (exe_fire && in_last_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         depth_ff     <= '0;
         index_ff     <= '0;
         err_ff       <= 1'b0;
         err_idx_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         depth_ff     <= depth_in;
         index_ff     <= index_in;
         err_ff       <= err_in;
         err_idx_ff   <= err_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff  <= req_tdata[3:0];
         in_arg_ff  <= req_tdata[11:4];
         in_last_ff <= req_tlast;
      end
      out_status_ff <= out_status_in;
      out_value_ff  <= out_value_in;
      out_detail_ff <= out_detail_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_detail_ff, out_value_ff, out_status_ff};

endmodule

// ===== hw/rtl/bspe_exec.sv =====
// bspe_exec: decodes one command against the top three stack entries
// and the depth; depends on bspe_pkg
module bspe_exec
   import bspe_pkg::*;
(
   input  logic [CMD_W-1:0]   cmd,
   input  logic [DATA_W-1:0]  arg,
   input  logic [DATA_W-1:0]  s0,
   input  logic [DATA_W-1:0]  s1,
   input  logic [DATA_W-1:0]  s2,
   input  logic [DEPTH_W-1:0] depth,
   output exec_type           ex
);

   localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH - 1);

   always_comb begin
      ex.bad        = 1'b0;
      ex.op         = SOP_HOLD;
      ex.top        = s0;
      ex.depth_next = depth;
      unique case (cmd)
         CMD_PUSH0, CMD_PUSH1, CMD_PUSHA: begin
            ex.bad        = (depth >= DEPTH_FULL);
            ex.op         = SOP_PUSH;
            ex.depth_next = depth + DEPTH_W'(1);
            if (cmd == CMD_PUSH0) begin
               ex.top = '0;
            end else if (cmd == CMD_PUSH1) begin
               ex.top = DATA_W'(1);
            end else begin
               ex.top = arg;
            end
         end
         CMD_NOT, CMD_SHL1, CMD_SHR1, CMD_SHR2, CMD_SHR4: begin
            ex.bad = (depth == '0);
            ex.op  = SOP_REPLACE;
            unique case (cmd)
               CMD_NOT:  ex.top = ~s0;
               CMD_SHL1: ex.top = s0 << 1;
               CMD_SHR1: ex.top = s0 >> 1;
               CMD_SHR2: ex.top = s0 >> 2;
               default:  ex.top = s0 >> 4;
            endcase
         end
         CMD_AND, CMD_OR, CMD_XOR, CMD_ADD: begin
            ex.bad        = (depth <= DEPTH_W'(1));
            ex.op         = SOP_POP1;
            ex.depth_next = depth - DEPTH_W'(1);
            unique case (cmd)
               CMD_AND: ex.top = s1 & s0;
               CMD_OR:  ex.top = s1 | s0;
               CMD_XOR: ex.top = s1 ^ s0;
               default: ex.top = s1 + s0;
            endcase
         end
         CMD_IFZERO: begin
            // pops condition, then-value, else-value
            ex.bad        = (depth <= DEPTH_W'(2));
            ex.op         = SOP_POP2;
            ex.depth_next = depth - DEPTH_W'(2);
            ex.top        = (s0 == '0) ? s1 : s2;
         end
         default: begin
            // unknown command counts as an error, reported as a range error
            ex.bad = 1'b1;
         end
      endcase
      if (ex.bad) begin
         ex.op         = SOP_HOLD;
         ex.depth_next = depth;
      end
   end

endmodule

// ===== hw/rtl/bspe_stack.sv =====
// bspe_stack: byte stack held as a shift line, entry 0 is the top
// depends on bspe_pkg
module bspe_stack
   import bspe_pkg::*;
(
   input  logic              clock,
   input  logic              enable,
   input  exec_type          ex,
   output logic [DATA_W-1:0] s0,
   output logic [DATA_W-1:0] s1,
   output logic [DATA_W-1:0] s2
);

   logic [DATA_W-1:0] stk_ff [STACK_DEPTH];
   logic [DATA_W-1:0] stk_in [STACK_DEPTH];

   always_comb begin
      stk_in = stk_ff;
      unique case (ex.op)
         SOP_HOLD: begin
         end
         SOP_PUSH: begin
            stk_in[0] = ex.top;
            for (int i = 1; i < STACK_DEPTH; i++) stk_in[i] = stk_ff[i-1];
         end
         SOP_REPLACE: begin
            stk_in[0] = ex.top;
         end
         SOP_POP1: begin
            stk_in[0] = ex.top;
            for (int i = 1; i < STACK_DEPTH - 1; i++) stk_in[i] = stk_ff[i+1];
         end
         SOP_POP2: begin
            stk_in[0] = ex.top;
            for (int i = 1; i < STACK_DEPTH - 2; i++) stk_in[i] = stk_ff[i+2];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stk_ff <= stk_in;
      end
   end

   assign s0 = stk_ff[0];
   assign s1 = stk_ff[1];
   assign s2 = stk_ff[2];

endmodule
